@@ src/assert_macros.svh @@
// Assertion macros shared by the neuron block RTL.
// Depends on nothing; included by modules that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/rlk_pkg.sv @@
// Package for the Rulkov map neuron: FSM states, command and status types.
// Depends on nothing.
`timescale 1ns / 1ps
package rlk_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SUM, ST_DIV, ST_FIN, ST_OUT
  } rlk_state_t;

  typedef enum logic [1:0] {
    DIV_NONE, DIV_MAP, DIV_INTERP
  } rlk_div_t;

  localparam logic [2:0] REG_ALPHA = 3'd0;
  localparam logic [2:0] REG_MU    = 3'd1;
  localparam logic [2:0] REG_SIGMA = 3'd2;
  localparam logic [2:0] REG_GAIN  = 3'd3;
  localparam logic [2:0] REG_STEPS = 3'd4;

  typedef struct packed {
    logic       load;
    logic       mul1;
    logic       mul2;
    logic       mul3;
    logic       sum;
    logic       div_start;
    logic       finish;
  } rlk_cmd_t;

  typedef struct packed {
    logic use_div;
    logic div_done;
  } rlk_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

@@ src/rlk_if.sv @@
// Valid/ready channel interface carrying a payload word.
// Depends on nothing.
`timescale 1ns / 1ps
interface rlk_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/rlk_ctrl.sv @@
// Controller FSM of the Rulkov neuron; sequences the datapath.
// Depends on rlk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rlk_ctrl
  import rlk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rlk_cmd_t  cmd,
  input  rlk_stat_t stat
);
  rlk_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin cmd.mul1 = 1'b1; state_next = ST_MUL2; end
      ST_MUL2: begin cmd.mul2 = 1'b1; state_next = ST_MUL3; end
      ST_MUL3: begin cmd.mul3 = 1'b1; state_next = ST_SUM; end
      ST_SUM: begin
        cmd.sum = 1'b1;
        if (stat.use_div) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else state_next = ST_FIN;
      end
      ST_DIV: if (stat.div_done) state_next = ST_FIN;
      ST_FIN: begin cmd.finish = 1'b1; state_next = ST_OUT; end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_rdy_idle, clk, rst, in_ready, state == ST_IDLE && !out_valid)
  `ASSERT_NEXT(a_load_mul, clk, rst, cmd.load, state == ST_MUL1)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

@@ src/rlk_dp.sv @@
// Datapath of the Rulkov neuron: state, products, bit-serial divider.
// Depends on rlk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rlk_dp
  import rlk_pkg::*;
#(
  parameter int FRAC_BITS = 24,
  parameter int STEP_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rlk_cmd_t             cmd,
  output rlk_stat_t            stat,
  input  logic signed [31:0]   syn,
  input  logic signed [31:0]   alpha,
  input  logic signed [31:0]   mu_rate,
  input  logic signed [31:0]   sigma_bias,
  input  logic signed [31:0]   syn_gain,
  input  logic [STEP_BITS-1:0] steps,
  output logic signed [31:0]   fast_out,
  output logic signed [31:0]   slow_out
);
  // dividend magnitude width: alpha*ONE for the map, diff*count for interpolation
  localparam int DW = (FRAC_BITS > STEP_BITS + 2) ? 32 + FRAC_BITS : 34 + STEP_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [31:0] QONE = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] fast_var, slow_var, prev_fast, target_fast;
  logic [STEP_BITS-1:0] step_count;
  logic signed [31:0] syn_r, p_a, p_b, p_c, y_next, y_syn, lin;
  logic iterate;

  // dividend/divisor magnitudes, sign of quotient
  logic [DW-1:0] quo;
  logic [DW-1:0] rem;
  logic [32:0]   dvs;
  logic          qneg, busy;
  logic [CW-1:0] cnt;
  rlk_div_t      dmode;

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return sat32(66'(p >>> FRAC_BITS));
  endfunction

  logic signed [32:0] xp1;
  assign xp1 = 33'(fast_var) + 33'(QONE);
  logic [DW:0] rem_sh;
  assign rem_sh = {rem, quo[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_var <= -QONE;
      slow_var <= -(QONE * 3);
      prev_fast <= '0;
      target_fast <= '0;
      step_count <= '0;
      busy <= 1'b0;
    end else begin
      if (cmd.load) begin
        syn_r <= syn;
        iterate <= (step_count >= steps);
      end
      if (cmd.mul1) p_a <= qmul(mu_rate, sat32(66'(xp1)));
      if (cmd.mul2) p_b <= qmul(mu_rate, sigma_bias);
      if (cmd.mul3) p_c <= qmul(syn_r, syn_gain);
      if (cmd.sum) begin
        y_next <= sat32(66'(sat32(66'(slow_var) - 66'(p_a))) + 66'(p_b));
        y_syn <= sat32(66'(slow_var) - 66'(p_c));
        lin <= sat32(66'(alpha) + 66'(sat32(66'(slow_var) - 66'(p_c))));
        if (iterate && fast_var <= 0) begin
          // alpha*ONE / (ONE - x), truncate toward zero
          quo <= DW'(alpha[31] ? -66'(alpha) : 66'(alpha)) << FRAC_BITS;
          dvs <= 33'(33'(QONE) - 33'(fast_var));
          qneg <= alpha[31];
          dmode <= DIV_MAP;
          busy <= 1'b1;
        end else if (!iterate) begin
          // (target-prev)*count / steps
          logic signed [65:0] pr;
          pr = (66'(target_fast) - 66'(prev_fast)) * $signed({1'b0, step_count});
          quo <= DW'(pr[65] ? -pr : pr);
          dvs <= 33'(steps);
          qneg <= pr[65];
          dmode <= DIV_INTERP;
          busy <= 1'b1;
        end else dmode <= DIV_NONE;
        rem <= '0;
        cnt <= CW'(DW);
      end else if (busy) begin
        if (rem_sh >= (DW+1)'(dvs)) begin
          rem <= DW'(rem_sh - (DW+1)'(dvs));
          quo <= {quo[DW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW-1:0];
          quo <= {quo[DW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) busy <= 1'b0;
      end
      if (cmd.finish) begin
        logic signed [65:0] q;
        q = qneg ? -66'(quo) : 66'(quo);
        if (iterate) begin
          logic signed [31:0] xn;
          if (dmode == DIV_MAP) xn = sat32(q + 66'(y_syn));
          else if (fast_var >= lin) xn = -QONE;
          else xn = lin;
          prev_fast <= fast_var;
          target_fast <= xn;
          fast_var <= xn;
          slow_var <= y_next;
          step_count <= '0;
        end else begin
          fast_var <= sat32(66'(prev_fast) + q);
          step_count <= step_count + STEP_BITS'(1);
        end
      end
    end
  end

  assign stat.use_div = (iterate && fast_var <= 0) || !iterate;
  assign stat.div_done = !busy;
  assign fast_out = fast_var;
  assign slow_out = slow_var;

  `ASSERT_NEXT(a_div_go, clk, rst, cmd.div_start, busy)
  `ASSERT_IMPL(a_no_fin_busy, clk, rst, cmd.finish, !busy)
  `ASSERT_IMPL(a_div_range, clk, rst, busy, cnt != '0)
endmodule

@@ src/rulkov_map_neuron_interp.sv @@
// Top level of the Rulkov map neuron with fast-variable interpolation.
// Depends on rlk_pkg, rlk_if, rlk_ctrl, rlk_dp.
`timescale 1ns / 1ps
// One word in gives one word out. An interpolation tick, or a map tick where
// x <= 0, runs the shared restoring divider one quotient bit per cycle over
// max(32+FRAC_BITS, 34+STEP_BITS) bits (56 by default); a map tick where
// x > 0 skips the divider. The divider sets the rate. No new word is taken
// until the result of the last has been accepted. The user must write
// registers over the APB port only while the block is idle; the block
// itself does not enforce this.
module rulkov_map_neuron_interp
  import rlk_pkg::*;
#(
  parameter int FRAC_BITS = 24,
  parameter int STEP_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  rlk_if.sink         in_ch,
  rlk_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic signed [31:0] alpha, mu_rate, sigma_bias, syn_gain;
  logic [STEP_BITS-1:0] interp_steps;
  logic signed [31:0] fast_out, slow_out;
  rlk_cmd_t  cmd;
  rlk_stat_t stat;

  assign pready = 1'b1;

  // register file: write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 32'sd67108864;
      mu_rate <= 32'sd16777;
      sigma_bias <= '0;
      syn_gain <= 32'sd16777216;
      interp_steps <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_ALPHA: alpha <= pwdata;
        REG_MU:    mu_rate <= pwdata;
        REG_SIGMA: sigma_bias <= pwdata;
        REG_GAIN:  syn_gain <= pwdata;
        REG_STEPS: interp_steps <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ALPHA: prdata = alpha;
      REG_MU:    prdata = mu_rate;
      REG_SIGMA: prdata = sigma_bias;
      REG_GAIN:  prdata = syn_gain;
      REG_STEPS: prdata = 32'(interp_steps);
      default:   prdata = '0;
    endcase
  end

  rlk_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .stat
  );

  rlk_dp #(.FRAC_BITS(FRAC_BITS), .STEP_BITS(STEP_BITS)) u_dp (
    .clk, .rst, .cmd, .stat,
    .syn(in_ch.data[31:0]),
    .alpha, .mu_rate, .sigma_bias, .syn_gain,
    .steps(interp_steps),
    .fast_out, .slow_out
  );

  // result word: fast variable in the low half, slow in the high half
  assign out_ch.data = {slow_out, fast_out};
endmodule
